@@ sv/rmbn_pkg.sv @@
`timescale 1ns / 1ps
// rmbn_pkg: shared types and constants for the rotation matrix block
// no dependencies

package rmbn_pkg;

	localparam int KW     = 33;      // cross product / dot product width
	localparam int ENT_W  = 16;      // matrix entry width
	localparam int ENT_MAX = 32767;
	localparam int ENT_MIN = -32768;

	typedef enum logic [1:0] {
		CASE_GENERAL = 2'd0,
		CASE_IDENT   = 2'd1,
		CASE_NEG     = 2'd2
	} case_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic signed [KW-1:0] kx, ky, kz;
		logic signed [KW-1:0] d;
		case_t                cls;
	} desc_t;

	// finished result item
	typedef struct packed {
		logic [8:0][ENT_W-1:0] ent;
		case_t                 cls;
	} res_t;

endpackage

@@ sv/rmbn_fifo.sv @@
`timescale 1ns / 1ps
// rmbn_fifo: small register queue with count, full and empty
// no package dependencies

module rmbn_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             pop,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("queue count did not follow a write");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

@@ sv/rmbn_front.sv @@
`timescale 1ns / 1ps
// rmbn_front: takes vector pairs, forms cross and dot products, classifies the item
// depends on rmbn_pkg

module rmbn_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic signed [15:0]    from_x,
	input  logic signed [15:0]    from_y,
	input  logic signed [15:0]    from_z,
	input  logic signed [15:0]    to_x,
	input  logic signed [15:0]    to_y,
	input  logic signed [15:0]    to_z,
	output logic                  dsc_vld,
	output rmbn_pkg::desc_t       dsc,
	input  logic                  dsc_full
);

	logic en;
	logic vld_s1, vld_s2, vld_s3;

	logic signed [15:0] ax_s1, ay_s1, az_s1, bx_s1, by_s1, bz_s1;
	logic signed [31:0] p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;
	logic signed [31:0] p_xx_s2, p_yy_s2, p_zz_s2;
	logic               eq_s2, op_s2;
	rmbn_pkg::desc_t    dsc_s3;

	logic signed [16:0] ax_w, ay_w, az_w, bx_w, by_w, bz_w;
	logic signed [rmbn_pkg::KW-1:0] kx, ky, kz, dd;
	rmbn_pkg::case_t    cls;

	assign en      = !(vld_s3 && dsc_full);
	assign full    = !en;
	assign dsc_vld = vld_s3;
	assign dsc     = dsc_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= push;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// opposite test at full width, so negating the most negative code never matches
	always_comb begin
		ax_w = ax_s1;
		ay_w = ay_s1;
		az_w = az_s1;
		bx_w = bx_s1;
		by_w = by_s1;
		bz_w = bz_s1;
	end

	always_comb begin
		kx = p_yz_s2 - p_zy_s2;
		ky = p_zx_s2 - p_xz_s2;
		kz = p_xy_s2 - p_yx_s2;
		dd = p_xx_s2 + p_yy_s2 + p_zz_s2;
		if (eq_s2) begin
			cls = rmbn_pkg::CASE_IDENT;
		end else if (op_s2) begin
			cls = rmbn_pkg::CASE_NEG;
		end else if (kx == '0 && ky == '0 && kz == '0) begin
			cls = dd[rmbn_pkg::KW-1] ? rmbn_pkg::CASE_NEG : rmbn_pkg::CASE_IDENT;
		end else begin
			cls = rmbn_pkg::CASE_GENERAL;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1 <= from_x;
			ay_s1 <= from_y;
			az_s1 <= from_z;
			bx_s1 <= to_x;
			by_s1 <= to_y;
			bz_s1 <= to_z;

			p_yz_s2 <= ay_s1 * bz_s1;
			p_zy_s2 <= az_s1 * by_s1;
			p_zx_s2 <= az_s1 * bx_s1;
			p_xz_s2 <= ax_s1 * bz_s1;
			p_xy_s2 <= ax_s1 * by_s1;
			p_yx_s2 <= ay_s1 * bx_s1;
			p_xx_s2 <= ax_s1 * bx_s1;
			p_yy_s2 <= ay_s1 * by_s1;
			p_zz_s2 <= az_s1 * bz_s1;
			eq_s2   <= (ax_s1 == bx_s1) && (ay_s1 == by_s1) && (az_s1 == bz_s1);
			op_s2   <= (ax_w == -bx_w) && (ay_w == -by_w) && (az_w == -bz_w);

			dsc_s3.kx  <= kx;
			dsc_s3.ky  <= ky;
			dsc_s3.kz  <= kz;
			dsc_s3.d   <= dd;
			dsc_s3.cls <= cls;
		end
	end

endmodule

@@ sv/rmbn_back.sv @@
`timescale 1ns / 1ps
// rmbn_back: square root, axis division and Rodrigues assembly pipeline
// depends on rmbn_pkg

module rmbn_back #(
	parameter int FRAC_BITS = 14
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_vld,
	input  rmbn_pkg::desc_t in_dsc,
	output logic            in_pop,
	input  logic            out_full,
	output logic            out_vld,
	output rmbn_pkg::res_t  out_res
);

	localparam int F   = FRAC_BITS;
	localparam int SQN = 32;            // root digits
	localparam int DVN = F + 1;         // quotient bits
	localparam int NST = F + 43;        // pipeline registers in this unit
	localparam int NW  = 33 + F;        // dividend width
	localparam int UW  = F + 2;         // signed axis component
	localparam int EW  = 36;            // rounded term width
	localparam int OW  = 34;            // one minus cosine
	localparam int SNW = 26;            // sine
	localparam int PW  = UW + OW;       // widest product
	localparam int KW  = rmbn_pkg::KW;
	localparam int ENT_W = rmbn_pkg::ENT_W;

	localparam logic [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (F - 1);
	localparam logic signed [OW-1:0] ONE_O = {{(OW-1){1'b0}}, 1'b1} << F;
	localparam int ONE_INT = ((1 << F) > rmbn_pkg::ENT_MAX) ? rmbn_pkg::ENT_MAX : (1 << F);
	localparam int NEG_INT = (-(1 << F) < rmbn_pkg::ENT_MIN) ? rmbn_pkg::ENT_MIN : -(1 << F);
	localparam logic [ENT_W-1:0] ONE_SAT = ONE_INT[ENT_W-1:0];
	localparam logic [ENT_W-1:0] NEG_SAT = NEG_INT[ENT_W-1:0];

	typedef struct packed {
		logic [2:0][31:0]      kmag;
		logic [2:0]            kneg;
		logic signed [KW-1:0]  d;
		rmbn_pkg::case_t       cls;
	} sq_pay_t;

	typedef struct packed {
		logic [2:0]            kneg;
		logic [31:0]           den;
		logic signed [EW-1:0]  cs;
		logic signed [SNW-1:0] sn;
		logic signed [OW-1:0]  omc;
		rmbn_pkg::case_t       cls;
	} dv_pay_t;

	function automatic logic signed [EW-1:0] rnd_f(input logic signed [PW-1:0] v);
		logic [PW:0] mag;
		logic [PW:0] sh;
		mag = v[PW-1] ? (~{v[PW-1], v} + 1'b1) : {1'b0, v};
		sh  = (mag + HALF) >> F;
		return v[PW-1] ? signed'(~sh[EW-1:0] + 1'b1) : signed'(sh[EW-1:0]);
	endfunction

	function automatic logic [ENT_W-1:0] sat_f(input logic signed [EW:0] v);
		logic [ENT_W-1:0] r;
		if (v > rmbn_pkg::ENT_MAX) begin
			r = ONE_INT[ENT_W-1:0] | 16'h7fff;
		end else if (v < rmbn_pkg::ENT_MIN) begin
			r = 16'h8000;
		end else begin
			r = v[ENT_W-1:0];
		end
		return r;
	endfunction

	logic            en;
	logic [NST-1:0]  vld_q;

	assign en      = !out_full;
	assign in_pop  = en && in_vld;
	assign out_vld = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_vld};
		end
	end

	// magnitudes, squares, squared length
	sq_pay_t      pay_s1, pay_s2, pay_s3;
	logic [63:0]  sqr_s2 [3];
	logic [63:0]  len_s3;
	sq_pay_t      pay_in;
	logic [KW-1:0] kraw [3];
	logic [KW-1:0] kabs [3];

	always_comb begin
		kraw[0] = in_dsc.kx;
		kraw[1] = in_dsc.ky;
		kraw[2] = in_dsc.kz;
		for (int l = 0; l < 3; l++) begin
			kabs[l] = kraw[l][KW-1] ? (~kraw[l] + 1'b1) : kraw[l];
			pay_in.kmag[l] = kabs[l][31:0];
			pay_in.kneg[l] = kraw[l][KW-1];
		end
		pay_in.d   = in_dsc.d;
		pay_in.cls = in_dsc.cls;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s1 <= pay_in;
			for (int l = 0; l < 3; l++) begin
				sqr_s2[l] <= 64'(pay_s1.kmag[l]) * 64'(pay_s1.kmag[l]);
			end
			pay_s2 <= pay_s1;
			len_s3 <= sqr_s2[0] + sqr_s2[1] + sqr_s2[2];
			pay_s3 <= pay_s2;
		end
	end

	// square root, one digit per stage
	logic [33:0] sq_rem_s  [SQN];
	logic [31:0] sq_root_s [SQN];
	logic [63:0] sq_rad_s  [SQN];
	sq_pay_t     sq_pay_s  [SQN];

	for (genvar gi = 0; gi < SQN; gi++) begin : g_sqrt
		logic [33:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] rad_in;
		sq_pay_t     pay_prev;
		logic [35:0] remx, trial;
		logic        ge;

		if (gi == 0) begin : g_first
			assign rem_in   = '0;
			assign root_in  = '0;
			assign rad_in   = len_s3;
			assign pay_prev = pay_s3;
		end else begin : g_next
			assign rem_in   = sq_rem_s[gi-1];
			assign root_in  = sq_root_s[gi-1];
			assign rad_in   = sq_rad_s[gi-1];
			assign pay_prev = sq_pay_s[gi-1];
		end

		assign remx  = {rem_in, rad_in[63:62]};
		assign trial = {2'b00, root_in, 2'b01};
		assign ge    = (remx >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[gi]  <= ge ? 34'(remx - trial) : remx[33:0];
				sq_root_s[gi] <= {root_in[30:0], ge};
				sq_rad_s[gi]  <= {rad_in[61:0], 2'b00};
				sq_pay_s[gi]  <= pay_prev;
			end
		end
	end

	// dividends, cosine, sine, one minus cosine
	logic [31:0]  rem0_s4 [3];
	logic [F:0]   low0_s4 [3];
	dv_pay_t      dpay_s4;
	logic [NW-1:0] num [3];
	logic [31:0]  root_f;
	sq_pay_t      pay_f;
	logic signed [EW-1:0] cs_w, sn_w;
	dv_pay_t      dpay_in;

	always_comb begin
		root_f = sq_root_s[SQN-1];
		pay_f  = sq_pay_s[SQN-1];
		for (int l = 0; l < 3; l++) begin
			num[l] = (NW'(pay_f.kmag[l]) << F) + NW'(root_f >> 1);
		end
		cs_w = rnd_f(pay_f.d);
		sn_w = rnd_f(signed'({1'b0, root_f}));
		dpay_in.kneg = pay_f.kneg;
		dpay_in.den  = root_f;
		dpay_in.cs   = cs_w;
		dpay_in.sn   = signed'(sn_w[SNW-1:0]);
		dpay_in.omc  = ONE_O - signed'(cs_w[OW-1:0]);
		dpay_in.cls  = pay_f.cls;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				rem0_s4[l] <= num[l][NW-1:F+1];
				low0_s4[l] <= num[l][F:0];
			end
			dpay_s4 <= dpay_in;
		end
	end

	// restoring division, one quotient bit per stage, three lanes
	logic [31:0] dv_rem_s [DVN][3];
	logic [F:0]  dv_low_s [DVN][3];
	logic [F:0]  dv_q_s   [DVN][3];
	dv_pay_t     dv_pay_s [DVN];

	for (genvar gj = 0; gj < DVN; gj++) begin : g_div
		logic [31:0] rem_in [3];
		logic [F:0]  low_in [3];
		logic [F:0]  q_in   [3];
		dv_pay_t     pay_prev;
		logic [32:0] t      [3];
		logic        ge     [3];

		if (gj == 0) begin : g_first
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_in[l] = rem0_s4[l];
					low_in[l] = low0_s4[l];
					q_in[l]   = '0;
				end
				pay_prev = dpay_s4;
			end
		end else begin : g_next
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_in[l] = dv_rem_s[gj-1][l];
					low_in[l] = dv_low_s[gj-1][l];
					q_in[l]   = dv_q_s[gj-1][l];
				end
				pay_prev = dv_pay_s[gj-1];
			end
		end

		always_comb begin
			for (int l = 0; l < 3; l++) begin
				t[l]  = {rem_in[l], low_in[l][F]};
				ge[l] = (t[l] >= {1'b0, pay_prev.den});
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < 3; l++) begin
					dv_rem_s[gj][l] <= ge[l] ? 32'(t[l] - {1'b0, pay_prev.den}) : t[l][31:0];
					dv_low_s[gj][l] <= low_in[l] << 1;
					dv_q_s[gj][l]   <= {q_in[l][F-1:0], ge[l]};
				end
				dv_pay_s[gj] <= pay_prev;
			end
		end
	end

	// signed axis, products, rounding, final sums
	logic signed [UW-1:0]     u_s5   [3];
	dv_pay_t                  pay_s5, pay_s6, pay_s7, pay_s8, pay_s9;
	logic signed [2*UW-1:0]   uu_s6  [6];
	logic signed [UW+SNW-1:0] su_s6  [3];
	logic signed [UW-1:0]     uur_s7 [6];
	logic signed [EW-1:0]     sr_s7  [3];
	logic signed [PW-1:0]     pr_s8  [6];
	logic signed [EW-1:0]     sr_s8  [3];
	logic signed [EW-1:0]     tr_s9  [6];
	logic signed [EW-1:0]     sr_s9  [3];
	rmbn_pkg::res_t           res_s10;

	logic signed [UW-1:0] uq   [3];
	logic signed [EW-1:0] rw   [6];
	logic signed [EW:0]   sm   [9];
	rmbn_pkg::res_t       res_n;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			uq[l] = signed'({1'b0, dv_q_s[DVN-1][l]});
		end
		for (int m = 0; m < 6; m++) begin
			rw[m] = rnd_f(uu_s6[m]);
		end
	end

	always_comb begin
		// xx yy zz xy xz yz, then sx sy sz
		sm[0] = pay_s9.cs + tr_s9[0];
		sm[1] = tr_s9[3] - sr_s9[2];
		sm[2] = tr_s9[4] + sr_s9[1];
		sm[3] = tr_s9[3] + sr_s9[2];
		sm[4] = pay_s9.cs + tr_s9[1];
		sm[5] = tr_s9[5] - sr_s9[0];
		sm[6] = tr_s9[4] - sr_s9[1];
		sm[7] = tr_s9[5] + sr_s9[0];
		sm[8] = pay_s9.cs + tr_s9[2];
		res_n.cls = pay_s9.cls;
		for (int i = 0; i < 9; i++) begin
			if (pay_s9.cls == rmbn_pkg::CASE_GENERAL) begin
				res_n.ent[i] = sat_f(sm[i]);
			end else if (i == 0 || i == 4 || i == 8) begin
				res_n.ent[i] = (pay_s9.cls == rmbn_pkg::CASE_IDENT) ? ONE_SAT : NEG_SAT;
			end else begin
				res_n.ent[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 3; l++) begin
				u_s5[l] <= dv_pay_s[DVN-1].kneg[l] ? -uq[l] : uq[l];
			end
			pay_s5 <= dv_pay_s[DVN-1];

			uu_s6[0] <= u_s5[0] * u_s5[0];
			uu_s6[1] <= u_s5[1] * u_s5[1];
			uu_s6[2] <= u_s5[2] * u_s5[2];
			uu_s6[3] <= u_s5[0] * u_s5[1];
			uu_s6[4] <= u_s5[0] * u_s5[2];
			uu_s6[5] <= u_s5[1] * u_s5[2];
			for (int l = 0; l < 3; l++) begin
				su_s6[l] <= u_s5[l] * pay_s5.sn;
			end
			pay_s6 <= pay_s5;

			for (int m = 0; m < 6; m++) begin
				uur_s7[m] <= signed'(rw[m][UW-1:0]);
			end
			for (int l = 0; l < 3; l++) begin
				sr_s7[l] <= rnd_f(su_s6[l]);
			end
			pay_s7 <= pay_s6;

			for (int m = 0; m < 6; m++) begin
				pr_s8[m] <= uur_s7[m] * pay_s7.omc;
			end
			sr_s8  <= sr_s7;
			pay_s8 <= pay_s7;

			for (int m = 0; m < 6; m++) begin
				tr_s9[m] <= rnd_f(pr_s8[m]);
			end
			sr_s9  <= sr_s8;
			pay_s9 <= pay_s8;

			res_s10 <= res_n;
		end
	end

	assign out_res = res_s10;

endmodule

@@ sv/rotation_matrix_between_normals.sv @@
`timescale 1ns / 1ps
// throughput: one item per cycle while the result queue has room
// the 32-stage root and FRAC_BITS + 1 stage divider set the pipeline depth
// stalls: a full result queue freezes the back pipeline, the middle queue then fills the front
// reset: arst_n clears all valid bits and queue pointers at once; data registers keep garbage
// depends on rmbn_pkg, rmbn_fifo, rmbn_front, rmbn_back

module rotation_matrix_between_normals #(
	parameter int FRAC_BITS = 14,
	parameter int MID_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] from_x,
	input  logic signed [15:0] from_y,
	input  logic signed [15:0] from_z,
	input  logic signed [15:0] to_x,
	input  logic signed [15:0] to_y,
	input  logic signed [15:0] to_z,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] row0_col0,
	output logic signed [15:0] row0_col1,
	output logic signed [15:0] row0_col2,
	output logic signed [15:0] row1_col0,
	output logic signed [15:0] row1_col1,
	output logic signed [15:0] row1_col2,
	output logic signed [15:0] row2_col0,
	output logic signed [15:0] row2_col1,
	output logic signed [15:0] row2_col2,
	output logic [1:0]         case_taken
);

	// front to middle queue
	logic            f_vld;
	rmbn_pkg::desc_t f_dsc;
	logic            q_full, q_empty;
	logic [$bits(rmbn_pkg::desc_t)-1:0] q_rdata;
	rmbn_pkg::desc_t q_dsc;

	// back to result queue
	logic            b_pop;
	logic            b_vld;
	rmbn_pkg::res_t  b_res;
	logic            o_full;
	logic [$bits(rmbn_pkg::res_t)-1:0] o_rdata;
	rmbn_pkg::res_t  o_res;

	// front: input registers, products, classification of the item
	rmbn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.from_x   (from_x),
		.from_y   (from_y),
		.from_z   (from_z),
		.to_x     (to_x),
		.to_y     (to_y),
		.to_z     (to_z),
		.dsc_vld  (f_vld),
		.dsc      (f_dsc),
		.dsc_full (q_full)
	);

	// decoupling queue so the front keeps taking items while the back is stalled, until this queue fills
	rmbn_fifo #(
		.WIDTH ($bits(rmbn_pkg::desc_t)),
		.DEPTH (MID_DEPTH)
	) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_vld && !q_full),
		.pop    (b_pop),
		.wdata  (f_dsc),
		.rdata  (q_rdata),
		.full   (q_full),
		.empty  (q_empty)
	);

	assign q_dsc = rmbn_pkg::desc_t'(q_rdata);

	// back: square root, normalization, Rodrigues terms, saturation
	rmbn_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (!q_empty),
		.in_dsc   (q_dsc),
		.in_pop   (b_pop),
		.out_full (o_full),
		.out_vld  (b_vld),
		.out_res  (b_res)
	);

	// result queue; head entry drives the result ports while empty is low
	rmbn_fifo #(
		.WIDTH ($bits(rmbn_pkg::res_t)),
		.DEPTH (OUT_DEPTH)
	) u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_vld && !o_full),
		.pop    (pop && !empty),
		.wdata  (b_res),
		.rdata  (o_rdata),
		.full   (o_full),
		.empty  (empty)
	);

	assign o_res = rmbn_pkg::res_t'(o_rdata);

	// row-major unpacking
	assign row0_col0  = o_res.ent[0];
	assign row0_col1  = o_res.ent[1];
	assign row0_col2  = o_res.ent[2];
	assign row1_col0  = o_res.ent[3];
	assign row1_col1  = o_res.ent[4];
	assign row1_col2  = o_res.ent[5];
	assign row2_col0  = o_res.ent[6];
	assign row2_col1  = o_res.ent[7];
	assign row2_col2  = o_res.ent[8];
	assign case_taken = o_res.cls;

endmodule

@@ verif/rotation_matrix_between_normals_test.sv @@
`timescale 1ns / 1ps
// rotation_matrix_between_normals_test: checks the rotation matrix block against its own predictor
// depends on rmbn_pkg and rotation_matrix_between_normals

module rotation_matrix_between_normals_test;

	localparam int FB = 14;
	localparam longint ONE = 64'sd1 <<< FB;
	localparam longint LIMIT = 400000;

	// one predicted matrix plus case code
	typedef struct {
		logic signed [15:0] m [9];
		rmbn_pkg::case_t    kind;
	} matrix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic full, empty;
	logic signed [15:0] from_x = '0, from_y = '0, from_z = '0;
	logic signed [15:0] to_x = '0, to_y = '0, to_z = '0;
	logic signed [15:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
	logic [1:0] case_taken;

	matrix_t pending_matrices [$];
	int errors = 0;
	int items_sent = 0;
	int items_checked = 0;
	int send_idle_pct = 0;
	int pop_stall_pct = 0;
	longint cycle_count = 0;

	rotation_matrix_between_normals dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.from_x(from_x), .from_y(from_y), .from_z(from_z),
		.to_x(to_x), .to_y(to_y), .to_z(to_z),
		.empty(empty), .pop(pop),
		.row0_col0(r00), .row0_col1(r01), .row0_col2(r02),
		.row1_col0(r10), .row1_col1(r11), .row1_col2(r12),
		.row2_col0(r20), .row2_col1(r21), .row2_col2(r22),
		.case_taken(case_taken)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// round to nearest, ties away from zero
	function automatic longint round_shift(longint v);
		longint m;
		m = (v < 0) ? -v : v;
		m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
		return (v < 0) ? -m : m;
	endfunction

	function automatic longint round_div(longint num, longint den);
		longint m, q;
		m = (num < 0) ? -num : num;
		q = ((m <<< FB) + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint fx_mul(longint p, longint q);
		return round_shift(p * q);
	endfunction

	// unsigned squares so large radicands do not wrap
	function automatic longint int_sqrt(longint v);
		longint unsigned r, t, uv;
		uv = v;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r + (64'd1 << b);
			if (t * t <= uv)
				r = t;
		end
		return longint'(r);
	endfunction

	function automatic logic signed [15:0] clamp16(longint v);
		if (v > rmbn_pkg::ENT_MAX) return 16'sh7fff;
		if (v < rmbn_pkg::ENT_MIN) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic matrix_t scaled_identity(longint diag, rmbn_pkg::case_t kind);
		matrix_t r;
		for (int i = 0; i < 9; i++)
			r.m[i] = (i % 4 == 0) ? clamp16(diag) : 16'sd0;
		r.kind = kind;
		return r;
	endfunction

	// rodrigues rotation in fixed point
	function automatic matrix_t rotation_between(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		longint kx, ky, kz, d, len2, s2, cs, sn, omc, ux, uy, uz;
		longint xx, yy, zz, xy, xz, yz, sx, sy, sz;
		matrix_t r;
		if (ax == bx && ay == by && az == bz)
			return scaled_identity(ONE, rmbn_pkg::CASE_IDENT);
		if (ax == -bx && ay == -by && az == -bz)
			return scaled_identity(-ONE, rmbn_pkg::CASE_NEG);
		kx = ay * bz - az * by;
		ky = az * bx - ax * bz;
		kz = ax * by - ay * bx;
		d = ax * bx + ay * by + az * bz;
		len2 = kx * kx + ky * ky + kz * kz;
		if (len2 == 0)
			return (d >= 0) ? scaled_identity(ONE, rmbn_pkg::CASE_IDENT)
				: scaled_identity(-ONE, rmbn_pkg::CASE_NEG);
		s2 = int_sqrt(len2);
		cs = round_shift(d);
		sn = round_shift(s2);
		omc = ONE - cs;
		ux = round_div(kx, s2);
		uy = round_div(ky, s2);
		uz = round_div(kz, s2);
		xx = fx_mul(fx_mul(ux, ux), omc);
		yy = fx_mul(fx_mul(uy, uy), omc);
		zz = fx_mul(fx_mul(uz, uz), omc);
		xy = fx_mul(fx_mul(ux, uy), omc);
		xz = fx_mul(fx_mul(ux, uz), omc);
		yz = fx_mul(fx_mul(uy, uz), omc);
		sx = fx_mul(ux, sn);
		sy = fx_mul(uy, sn);
		sz = fx_mul(uz, sn);
		r.m[0] = clamp16(cs + xx);
		r.m[1] = clamp16(xy - sz);
		r.m[2] = clamp16(xz + sy);
		r.m[3] = clamp16(xy + sz);
		r.m[4] = clamp16(cs + yy);
		r.m[5] = clamp16(yz - sx);
		r.m[6] = clamp16(xz - sy);
		r.m[7] = clamp16(yz + sx);
		r.m[8] = clamp16(cs + zz);
		r.kind = rmbn_pkg::CASE_GENERAL;
		return r;
	endfunction

	// send one pair, with a random idle gap first; push stays high across back-to-back items
	task automatic send_pair(logic signed [15:0] ax, ay, az, bx, by, bz);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		push <= 1'b1;
		from_x <= ax; from_y <= ay; from_z <= az;
		to_x <= bx; to_y <= by; to_z <= bz;
		do @(posedge clk); while (full);
		pending_matrices.insert(pending_matrices.size(),
			rotation_between(ax, ay, az, bx, by, bz));
		items_sent++;
	endtask

	task automatic go_quiet();
		push <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp();
		return 16'($signed($urandom_range(32768)) - 16384);
	endfunction

	// random unit vector, approximately normalized
	task automatic rand_unit(output logic signed [15:0] x, y, z);
		real fx, fy, fz, n;
		do begin
			fx = $itor($signed($urandom_range(2000)) - 1000);
			fy = $itor($signed($urandom_range(2000)) - 1000);
			fz = $itor($signed($urandom_range(2000)) - 1000);
			n = $sqrt(fx * fx + fy * fy + fz * fz);
		end while (n < 1.0);
		x = $rtoi(fx / n * 16384.0);
		y = $rtoi(fy / n * 16384.0);
		z = $rtoi(fz / n * 16384.0);
	endtask

	task automatic wait_drained();
		go_quiet();
		while (pending_matrices.size() != 0) @(posedge clk);
	endtask

	// extremes, equal, opposite, collinear and zero-length inputs
	task automatic test_directed();
		send_pair(16384, 0, 0, 16384, 0, 0);
		send_pair(16384, 0, 0, -16384, 0, 0);
		send_pair(16384, 0, 0, 0, 16384, 0);
		send_pair(0, 16384, 0, 0, 0, 16384);
		send_pair(0, 0, 16384, 16384, 0, 0);
		send_pair(0, 0, 0, 0, 0, 0);
		send_pair(0, 0, 0, 16384, 0, 0);
		send_pair(8192, 0, 0, 16384, 0, 0);
		send_pair(8192, 0, 0, -16384, 0, 0);
		send_pair(-16384, -16384, -16384, 16384, 16384, 16384);
		send_pair(-32768, 0, 0, -32768, 0, 0);
		send_pair(-32768, -32768, -32768, -32768, -32768, -32768);
		send_pair(-32768, 0, 0, 32767, 0, 0);
		send_pair(32767, 32767, 32767, -32768, 32767, -32768);
		send_pair(-32768, -32768, -32768, 32767, 32767, 32767);
		send_pair(32767, -32768, 0, 0, 32767, -32768);
		send_pair(-1, -1, -1, 1, 1, 1);
		send_pair(11585, 11585, 0, 11585, -11585, 0);
		send_pair(16384, 1, 0, 16384, -1, 0);
		send_pair(9459, 9459, 9459, -9459, 9459, 9459);
		send_pair(16384, 0, 0, -16384, 1, 0);
		send_pair(-1, 0, 0, 0, -1, 0);
	endtask

	// mostly unit pairs, some near-collinear, some raw bit noise
	task automatic test_random(int count);
		logic signed [15:0] ax, ay, az, bx, by, bz;
		int pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			rand_unit(ax, ay, az);
			rand_unit(bx, by, bz);
			if (pick < 10) begin
				bx = ax + 16'($signed($urandom_range(6)) - 3);
				by = ay; bz = az;
			end else if (pick < 16) begin
				bx = -ax; by = -ay; bz = -az + 16'($urandom_range(1));
			end else if (pick < 24) begin
				ax = rand_comp(); ay = rand_comp(); az = rand_comp();
			end else if (pick < 32) begin
				ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
				bx = 16'($urandom); by = 16'($urandom); bz = 16'($urandom);
			end
			send_pair(ax, ay, az, bx, by, bz);
		end
	endtask

	// result side: random pop stalls, compare with the oldest prediction
	always @(posedge clk) begin
		matrix_t want;
		logic signed [15:0] got [9];
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{r00, r01, r02, r10, r11, r12, r20, r21, r22};
				if (pending_matrices.size() == 0) begin
					$display("%0t: unexpected item, case %0d", $time, case_taken);
					errors++;
				end else begin
					want = pending_matrices[0];
					pending_matrices.delete(0);
					for (int i = 0; i < 9; i++)
						if (got[i] !== want.m[i]) begin
							$display("%0t: entry %0d expected %0d got %0d",
								$time, i, want.m[i], got[i]);
							errors++;
						end
					if (case_taken !== want.kind) begin
						$display("%0t: case_taken expected %0d got %0d",
							$time, want.kind, case_taken);
						errors++;
					end
					items_checked++;
				end
			end
			pop <= !(pop_stall_pct > 0 && $urandom_range(99) < pop_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_random(150);
		send_idle_pct = 84;
		test_random(130);
		send_idle_pct = 0; pop_stall_pct = 84;
		test_random(130);
		send_idle_pct = 37; pop_stall_pct = 37;
		test_random(140);
		wait_drained();
		repeat (80) @(posedge clk);
		$display("sent %0d pairs (equal, opposite, collinear, saturating, random unit)",
			items_sent);
		$display("checked %0d matrices under four idle/stall mixes", items_checked);
		if (errors == 0 && pending_matrices.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

@@ rotation_matrix_between_normals.f @@
sv/rmbn_pkg.sv
sv/rmbn_fifo.sv
sv/rmbn_front.sv
sv/rmbn_back.sv
sv/rotation_matrix_between_normals.sv
verif/rotation_matrix_between_normals_test.sv
